### rtl/core/kts_pkg.sv
// Shared types and constants for the key/tag sorter.
package kts_pkg;

  localparam int unsigned KeyBits     = 16;
  localparam int unsigned TagBits     = 16;
  localparam int unsigned MaxItemsDef = 32;

  // Input request: one pair of the data set
  typedef struct packed {
    logic signed [KeyBits-1:0] key;
    logic [TagBits-1:0]        tag;
    logic                      last;
  } in_req_t;

  // Output request: one pair of the sorted run
  typedef struct packed {
    logic signed [KeyBits-1:0] key_out;
    logic [TagBits-1:0]        tag_out;
    logic                      last_out;
    logic                      overflow;
  } out_req_t;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic                      valid;
    logic signed [KeyBits-1:0] key;
    logic [TagBits-1:0]        tag;
  } cell_t;

  // Row-wide command to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DRAIN
  } kts_op_e;

endpackage

### rtl/core/kts_cell.sv
// One cell of the sorting row: holds a single pair, sorted against the broadcast key.
module kts_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kts_pkg::kts_op_e op_i,
  input  kts_pkg::in_req_t new_i,
  input  kts_pkg::cell_t  left_i,
  input  logic            left_gt_i,
  input  kts_pkg::cell_t  right_i,
  output kts_pkg::cell_t  cell_o,
  output logic            gt_o
);
  import kts_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [KeyBits-1:0] key_q, key_d;
  logic [TagBits-1:0]        tag_q, tag_d;
  logic                      ins;

  // Stored key sits after the new one: strict compare keeps arrival order on ties
  assign gt_o = valid_q && (key_q > new_i.key);

  // New pair lands here: left neighbour stays put and this slot moves or is free
  assign ins = (gt_o || !valid_q) && left_i.valid && !left_gt_i;

  assign cell_o = '{valid: valid_q, key: key_q, tag: tag_q};

  // Next contents
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    case (op_i)
      CELL_LOAD: begin
        if (left_gt_i) begin
          valid_d = left_i.valid;
          key_d   = left_i.key;
          tag_d   = left_i.tag;
        end else if (ins) begin
          valid_d = 1'b1;
          key_d   = new_i.key;
          tag_d   = new_i.tag;
        end
      end
      CELL_DRAIN: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
        tag_d   = right_i.tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

endmodule

### rtl/core/key_tag_sorter.sv
// Stable key/tag sorter built from a row of insertion cells, top level.
//
// Pairs load at one per cycle while in_stall_o is low; each is broadcast to
// a row of MAX_ITEMS cells, every cell compares it with its own key in the
// same cycle, and the row stays sorted after each load. The pair flagged last
// closes the set; from the next cycle the row shifts towards the output one
// cell per taken request, with in_stall_o high throughout. Equal keys leave
// in arrival order. Pairs arriving while the row is full are dropped and the
// final output request then carries overflow.
module key_tag_sorter #(
  parameter int unsigned MAX_ITEMS = kts_pkg::MaxItemsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kts_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kts_pkg::out_req_t out_req_o
);
  import kts_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  cell_t             cells   [MAX_ITEMS];
  logic              gts     [MAX_ITEMS];
  cell_t             lefts   [MAX_ITEMS];
  logic              left_gts[MAX_ITEMS];
  cell_t             rights  [MAX_ITEMS];
  kts_op_e           op;
  logic [CntW-1:0]   count_q, count_d;
  logic              drop_q, drop_d;
  logic              drain_q, drain_d;
  logic              in_acc, out_acc, full, final_one;

  assign in_stall_o  = drain_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = drain_q;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (count_q == CntW'(MAX_ITEMS));
  assign final_one   = !cells[1].valid;

  // Neighbour wiring; cell 0's fixed left neighbour is occupied, never greater
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (i == 0) begin
        lefts[i]    = '{valid: 1'b1, key: '0, tag: '0};
        left_gts[i] = 1'b0;
      end else begin
        lefts[i]    = cells[i-1];
        left_gts[i] = gts[i-1];
      end
      if (i == MAX_ITEMS - 1) begin
        rights[i] = '0;
      end else begin
        rights[i] = cells[i+1];
      end
    end
  end

  // Row command
  always_comb begin
    if (out_acc) begin
      op = CELL_DRAIN;
    end else if (in_acc && !full) begin
      op = CELL_LOAD;
    end else begin
      op = CELL_HOLD;
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    kts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .new_i     (in_req_i),
      .left_i    (lefts[g]),
      .left_gt_i (left_gts[g]),
      .right_i   (rights[g]),
      .cell_o    (cells[g]),
      .gt_o      (gts[g])
    );
  end

  // Fill count, drop flag and drain phase
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
      if (in_req_i.last) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc && final_one) begin
      count_d = '0;
      drop_d  = 1'b0;
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      drain_q <= drain_d;
    end
  end

  // Head cell is the output register
  assign out_req_o = '{key_out:  cells[0].key,
                       tag_out:  cells[0].tag,
                       last_out: final_one,
                       overflow: final_one && drop_q};

endmodule
